// File: hdl/potts_metropolis_site_update_3d_top_defines.svh
// Assertion macros for the lattice update RTL, used by the site engine.
`ifndef POTTS_METROPOLIS_SITE_UPDATE_3D_TOP_DEFINES_SVH
`define POTTS_METROPOLIS_SITE_UPDATE_3D_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define PMSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmsu check failed");
// Next-cycle implication, disabled while reset is low.
`define PMSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmsu check failed");
`else
`define PMSU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PMSU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/pmsu_pkg.sv
// Shared constants, codes and types for the Potts lattice update block.
`timescale 1ns / 1ps
package pmsu_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 5;
  localparam int VALUE_W = 8;
  localparam int RND_W   = 16;
  localparam int THR_W   = 17;
  localparam int CHG_W   = 4;

  // Threshold registers, one per negative change -1 .. -6
  localparam int NUM_THR = 6;
  localparam logic [THR_W-1:0] THR_RESET = 17'h10000;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Parameter defaults
  localparam int DEF_SIDE      = 32;
  localparam int DEF_SPIN_BITS = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef logic [NUM_THR-1:0][THR_W-1:0] thr_arr_t;

  typedef struct packed {
    logic                    accepted;
    logic [VALUE_W-1:0]      site_value;
    logic signed [CHG_W-1:0] energy_change;
  } res_t;

endpackage

// File: hdl/potts_metropolis_site_update_3d_top.sv
// Top level of the 3D Potts lattice Metropolis site update block.
// Update request: the site and its six neighbors are read in turn from the single-port
//   spin store (seven reads and at most one write per update), then the result is registered;
//   a read request reads the site only, and a write goes straight to the decision.
// After reset a clearing pass zeroes the store, one site per cycle (SIDE**3 sites,
//   32768 at the default size); no request is taken meanwhile, config writes are.
`timescale 1ns / 1ps
module potts_metropolis_site_update_3d_top import pmsu_pkg::*; #(
  parameter int SIDE      = DEF_SIDE,
  parameter int SPIN_BITS = DEF_SPIN_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] coord_x, [9:5] coord_y, [14:10] coord_z, [22:15] value_in,
  // [38:23] random_fraction, [39] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]        in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] accepted, [8:1] site_value, [12:9] energy_change, [15:13] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int ADDR_W = $clog2(SIDE * SIDE * SIDE);

  thr_arr_t               thr;
  res_t                   res;
  logic                   res_valid;
  logic                   out_free;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [SPIN_BITS-1:0]   ram_wdata;
  logic [SPIN_BITS-1:0]   ram_rdata;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  pmsu_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  pmsu_lattice_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SPIN_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pmsu_site_engine #(
    .SIDE      (SIDE),
    .SPIN_BITS (SPIN_BITS),
    .ADDR_W    (ADDR_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_x      (in_tdata[4:0]),
    .in_y      (in_tdata[9:5]),
    .in_z      (in_tdata[14:10]),
    .in_value  (in_tdata[22:15]),
    .in_rnd    (in_tdata[38:23]),
    .thr       (thr),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Output register: the engine may run the next request while a result waits
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_tdata_r <= OUT_TDATA_W'({res.energy_change, res.site_value, res.accepted});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: hdl/pmsu_lattice_ram.sv
// Single-port synchronous spin store with registered read.
`timescale 1ns / 1ps
module pmsu_lattice_ram import pmsu_pkg::*; #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = DEF_SPIN_BITS
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] spin_lattice [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // One access per cycle: write if enabled, and the addressed word is read out as well
  always_ff @(posedge clk) begin
    if (we) begin
      spin_lattice[addr] <= wdata;
    end
    rdata_r <= spin_lattice[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pmsu_cfg_regs.sv
// APB-style threshold register file.
`timescale 1ns / 1ps
module pmsu_cfg_regs import pmsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output thr_arr_t              thr
);

  thr_arr_t   thr_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes; addresses past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_THR; i++) begin
        thr_r[i] <= THR_RESET;
      end
    end else if (wr_en && (reg_idx < 3'(NUM_THR))) begin
      thr_r[reg_idx] <= cfg_pwdata[THR_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx < 3'(NUM_THR)) begin
      cfg_prdata = CFG_DATA_W'(thr_r[reg_idx]);
    end
  end

  assign thr = thr_r;

endmodule

// File: hdl/pmsu_site_engine.sv
// Read-modify-write sequencer: clear pass, neighbor reads, Metropolis decision.
`timescale 1ns / 1ps
`include "potts_metropolis_site_update_3d_top_defines.svh"
module pmsu_site_engine import pmsu_pkg::*; #(
  parameter int SIDE      = DEF_SIDE,
  parameter int SPIN_BITS = DEF_SPIN_BITS,
  parameter int ADDR_W    = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request side
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_op,
  input  logic [COORD_W-1:0]   in_x,
  input  logic [COORD_W-1:0]   in_y,
  input  logic [COORD_W-1:0]   in_z,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic [RND_W-1:0]     in_rnd,
  input  thr_arr_t             thr,
  // result side
  input  logic                 out_free,
  output logic                 res_valid,
  output res_t                 res,
  // store port
  output logic                 ram_we,
  output logic [ADDR_W-1:0]    ram_addr,
  output logic [SPIN_BITS-1:0] ram_wdata,
  input  logic [SPIN_BITS-1:0] ram_rdata
);

  localparam int SITES = SIDE * SIDE * SIDE;
  localparam int PLANE = SIDE * SIDE;
  localparam int CW    = $clog2(SIDE);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(SITES - 1);
  localparam logic [CW-1:0]     C_MAX    = CW'(SIDE - 1);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_LAST   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  // Read steps: site first, then the six neighbors
  localparam logic [2:0] NB_CENTER = 3'd0;
  localparam logic [2:0] NB_XDN    = 3'd1;
  localparam logic [2:0] NB_XUP    = 3'd2;
  localparam logic [2:0] NB_YDN    = 3'd3;
  localparam logic [2:0] NB_YUP    = 3'd4;
  localparam logic [2:0] NB_ZUP    = 3'd5;
  localparam logic [2:0] NB_ZDN    = 3'd6;

  logic [2:0]           state_r,   state_nxt;
  logic [2:0]           step_r,    step_nxt;
  logic                 rd_vld_r,  rd_vld_nxt;
  logic [2:0]           rd_step_r, rd_step_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [OP_W-1:0]      op_r,      op_nxt;
  logic [CW-1:0]        x_r,       x_nxt;
  logic [CW-1:0]        y_r,       y_nxt;
  logic [CW-1:0]        z_r,       z_nxt;
  logic [SPIN_BITS-1:0] val_r,     val_nxt;
  logic [RND_W-1:0]     rnd_r,     rnd_nxt;
  logic [SPIN_BITS-1:0] old_r,     old_nxt;
  logic [CHG_W-1:0]     change_r,  change_nxt;

  logic [CW-1:0]        coord_mod [2**COORD_W];
  logic [CW-1:0]        x_dn, x_up, y_dn, y_up, z_dn, z_up;
  logic [CW-1:0]        sx, sy, sz;
  logic [ADDR_W-1:0]    addr_calc;
  logic [2:0]           last_step;
  logic [CHG_W-1:0]     neg_chg;
  logic [2:0]           thr_idx;
  logic                 rnd_ok;
  logic                 upd_acc;
  logic                 acc;
  logic                 eq_new, eq_old;

  // Coordinate reduction table (identity when the side covers the field)
  for (genvar g = 0; g < 2**COORD_W; g++) begin : g_cmod
    assign coord_mod[g] = CW'(g % SIDE);
  end

  // Periodic neighbor coordinates
  assign x_dn = (x_r == '0)    ? C_MAX : x_r - CW'(1);
  assign x_up = (x_r == C_MAX) ? '0    : x_r + CW'(1);
  assign y_dn = (y_r == '0)    ? C_MAX : y_r - CW'(1);
  assign y_up = (y_r == C_MAX) ? '0    : y_r + CW'(1);
  assign z_dn = (z_r == '0)    ? C_MAX : z_r - CW'(1);
  assign z_up = (z_r == C_MAX) ? '0    : z_r + CW'(1);

  // Coordinate of the access in flight; the site itself outside the read phase
  always_comb begin
    sx = x_r;
    sy = y_r;
    sz = z_r;
    if (state_r == ST_READ) begin
      case (step_r)
        NB_XDN:  sx = x_dn;
        NB_XUP:  sx = x_up;
        NB_YDN:  sy = y_dn;
        NB_YUP:  sy = y_up;
        NB_ZUP:  sz = z_up;
        NB_ZDN:  sz = z_dn;
        default: sx = x_r;
      endcase
    end
  end

  assign addr_calc = ADDR_W'(sx) * ADDR_W'(PLANE) + ADDR_W'(sy) * ADDR_W'(SIDE)
                   + ADDR_W'(sz);

  assign last_step = (op_r == OP_UPDATE) ? NB_ZDN : NB_CENTER;

  // Neighbor match against proposed and current spin
  assign eq_new = (ram_rdata == val_r);
  assign eq_old = (ram_rdata == old_r);

  // Acceptance: an update on non-negative change always, else random against threshold; a write always, a read never
  assign neg_chg = CHG_W'(0) - change_r;
  assign thr_idx = 3'(neg_chg - CHG_W'(1));
  assign rnd_ok  = ({1'b0, rnd_r} <= thr[thr_idx]);
  assign upd_acc = !change_r[CHG_W-1] || rnd_ok;
  assign acc     = (op_r == OP_UPDATE) ? upd_acc : (op_r == OP_WRITE);

  // Result fields
  assign res.accepted      = acc;
  assign res.site_value    = VALUE_W'(acc ? val_r : old_r);
  assign res.energy_change = signed'(change_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    clr_addr_nxt = clr_addr_r;
    op_nxt       = op_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    val_nxt      = val_r;
    rnd_nxt      = rnd_r;
    old_nxt      = old_r;
    change_nxt   = change_r;
    rd_vld_nxt   = (state_r == ST_READ);
    rd_step_nxt  = step_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = addr_calc;
    ram_wdata    = val_r;

    // Read data returns in the cycle after its address
    if (rd_vld_r) begin
      if (rd_step_r == NB_CENTER) begin
        old_nxt = ram_rdata;
      end else begin
        change_nxt = change_r + CHG_W'(eq_new) - CHG_W'(eq_old);
      end
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_op;
          x_nxt      = coord_mod[in_x];
          y_nxt      = coord_mod[in_y];
          z_nxt      = coord_mod[in_z];
          val_nxt    = in_value[SPIN_BITS-1:0];
          rnd_nxt    = in_rnd;
          change_nxt = '0;
          step_nxt   = NB_CENTER;
          state_nxt  = (in_op == OP_WRITE) ? ST_DECIDE : ST_READ;
        end
      end
      ST_READ: begin
        step_nxt = step_r + 3'd1;
        if (step_r == last_step) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          res_valid = 1'b1;
          ram_we    = acc;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      step_r     <= NB_CENTER;
      rd_vld_r   <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      rd_vld_r   <= rd_vld_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Request payload and accumulators
  always_ff @(posedge clk) begin
    rd_step_r <= rd_step_nxt;
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    val_r     <= val_nxt;
    rnd_r     <= rnd_nxt;
    old_r     <= old_nxt;
    change_r  <= change_nxt;
  end

  `PMSU_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE)
  `PMSU_ASSERT_IMP(a_result_into_free_slot, clk, rst_n, res_valid, out_free)
  `PMSU_ASSERT_IMP(a_store_only_on_change, clk, rst_n, ram_we && (state_r != ST_CLEAR), (op_r == OP_UPDATE) || (op_r == OP_WRITE))
  `PMSU_ASSERT_IMP(a_last_read_pending, clk, rst_n, state_r == ST_LAST, rd_vld_r)
  `PMSU_ASSERT_NXT(a_clear_ends_idle, clk, rst_n, (state_r == ST_CLEAR) && (clr_addr_r == CLR_LAST), state_r == ST_IDLE)

endmodule
